// ===== sv/esr_pkg.sv =====
`default_nettype none
package esr_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_SOH,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_PAYLOAD,
    PH_SUM_HI,
    PH_SUM_LO
  } phase_t;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_BYTE    = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_GOOD        = 3'd1;
  localparam logic [2:0] ST_BAD_SUM     = 3'd2;
  localparam logic [2:0] ST_NAK_RX      = 3'd3;
  localparam logic [2:0] ST_TIMEOUT     = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;
  localparam logic [2:0] ST_PAY_TIMEOUT = 3'd6;

  localparam logic [15:0] MAX_COUNT_RESET = 16'd518;

endpackage
`default_nettype wire

// ===== sv/enq_soh_frame_receiver_sum16.sv =====
// Receiving side of an ENQ/SOH framed link with a 16-bit additive checksum.
// Input channel (in_valid/in_ready/in_item): one item per start request,
// received line byte or receive timeout. Output channel (out_valid/
// out_ready/out_item): exactly one result item per input item, in order,
// carrying the control byte to send, the forwarded payload byte and status.
// cfg_we/cfg_wdata write max_count (reset 518); write only while idle.
// Path: an accepted item lands in the input register, and its result is then
// registered in the result register, which drives out_valid and out_item.
// Throughput is one item per cycle while out_ready stays high, set by the
// combinational phase/checksum update between the input and result
// registers.
// Reset: both pipeline registers empty, phase idle, counters and sum zero,
// max_count back to 518.
// Stall: when out_ready is low the result register holds; the input
// register still takes one more item, after which in_ready drops until the
// result is taken.
`default_nettype none
module enq_soh_frame_receiver_sum16 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire esr_pkg::in_item_t  in_item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      esr_pkg::out_item_t out_item
);
  import esr_pkg::*;

  logic     s_valid;
  logic     s_ready;
  in_item_t s_item;

  esr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_item   (s_item)
  );

  esr_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_item    (s_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sv/esr_in_reg.sv =====
`default_nettype none
module esr_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire esr_pkg::in_item_t in_item,
  output      logic             s_valid,
  input  wire logic             s_ready,
  output      esr_pkg::in_item_t s_item
);
  import esr_pkg::*;

  logic     valid;
  in_item_t item;

  assign in_ready = !valid || s_ready;
  assign s_valid  = valid;
  assign s_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/esr_fsm.sv =====
`default_nettype none
module esr_fsm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              s_valid,
  output      logic              s_ready,
  input  wire esr_pkg::in_item_t s_item,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      esr_pkg::out_item_t out_item
);
  import esr_pkg::*;

  logic [15:0] max_count;
  phase_t      phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_high_byte, sum_high_byte_next;
  out_item_t   res;
  out_item_t   item;
  logic        valid;
  logic        take;
  logic [15:0] len_full;

  assign s_ready   = !valid || out_ready;
  assign take      = s_valid && s_ready;
  assign out_valid = valid;
  assign out_item  = item;
  assign len_full  = {frame_length[15:8], s_item.rx_byte};

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    running_sum_next   = running_sum;
    sum_high_byte_next = sum_high_byte;
    res                = '0;
    res.status         = ST_BUSY;
    case (s_item.func)
      FUNC_START: begin
        res.send_valid = 1'b1;
        res.send_byte  = CH_ENQ;
        phase_next     = PH_WAIT_SOH;
      end
      FUNC_TIMEOUT: begin
        if (phase == PH_WAIT_SOH || phase == PH_CNT_HI || phase == PH_CNT_LO) begin
          res.send_valid = 1'b1;
          res.send_byte  = CH_NAK;
          res.status     = ST_TIMEOUT;
          phase_next     = PH_IDLE;
        end else if (phase != PH_IDLE) begin
          res.send_valid = 1'b1;
          res.send_byte  = CH_NAK;
          res.status     = ST_PAY_TIMEOUT;
          phase_next     = PH_WAIT_SOH;
        end
      end
      FUNC_BYTE: begin
        unique case (phase)
          PH_WAIT_SOH: begin
            if (s_item.rx_byte == CH_SOH) begin
              phase_next = PH_CNT_HI;
            end else if (s_item.rx_byte == CH_NAK) begin
              res.status = ST_NAK_RX;
              phase_next = PH_IDLE;
            end
          end
          PH_CNT_HI: begin
            frame_length_next = {s_item.rx_byte, 8'h00};
            phase_next        = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            frame_length_next = len_full;
            running_sum_next  = '0;
            bytes_seen_next   = '0;
            if (len_full > max_count) begin
              res.send_valid = 1'b1;
              res.send_byte  = CH_NAK;
              res.status     = ST_TOO_LARGE;
              phase_next     = PH_IDLE;
            end else if (len_full == '0) begin
              phase_next = PH_SUM_HI;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res.data_valid   = 1'b1;
            res.data_byte    = s_item.rx_byte;
            running_sum_next = running_sum + {8'h00, s_item.rx_byte};
            bytes_seen_next  = bytes_seen + 16'd1;
            if (bytes_seen_next >= frame_length) begin
              phase_next = PH_SUM_HI;
            end
          end
          PH_SUM_HI: begin
            sum_high_byte_next = s_item.rx_byte;
            phase_next         = PH_SUM_LO;
          end
          PH_SUM_LO: begin
            res.send_valid = 1'b1;
            if ({sum_high_byte, s_item.rx_byte} == running_sum) begin
              res.send_byte = CH_ACK;
              res.status    = ST_GOOD;
              phase_next    = PH_IDLE;
            end else begin
              res.send_byte = CH_NAK;
              res.status    = ST_BAD_SUM;
              phase_next    = PH_WAIT_SOH;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (cfg_we) begin
      max_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_length  <= '0;
      bytes_seen    <= '0;
      running_sum   <= '0;
      sum_high_byte <= '0;
    end else if (take) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= res;
    end
  end

endmodule
`default_nettype wire

// ===== bench/frame_reply_checker.sv =====
`timescale 1ns / 1ps
module frame_reply_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  esr_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  esr_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 replies_pending
);
  import esr_pkg::*;

  phase_t      ph;
  logic [15:0] limit;
  logic [15:0] frame_len;
  logic [15:0] seen;
  logic [15:0] sum;
  logic [7:0]  sum_hi;
  out_item_t   replies_due[$];
  int          reply_idx;

  initial begin
    mismatches = 0;
    replies_pending = 0;
    reply_idx = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t reply %0d: %s", $time, reply_idx, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got)
      report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endtask

  function automatic out_item_t predict_reply(input in_item_t it);
    out_item_t r;
    r = '0;
    r.status = ST_BUSY;
    case (it.func)
      FUNC_START: begin
        r.send_valid = 1'b1;
        r.send_byte  = CH_ENQ;
        ph = PH_WAIT_SOH;
      end
      FUNC_TIMEOUT: begin
        if (ph == PH_WAIT_SOH || ph == PH_CNT_HI || ph == PH_CNT_LO) begin
          r.send_valid = 1'b1;
          r.send_byte  = CH_NAK;
          r.status     = ST_TIMEOUT;
          ph = PH_IDLE;
        end else if (ph == PH_PAYLOAD || ph == PH_SUM_HI || ph == PH_SUM_LO) begin
          r.send_valid = 1'b1;
          r.send_byte  = CH_NAK;
          r.status     = ST_PAY_TIMEOUT;
          ph = PH_WAIT_SOH;
        end
      end
      FUNC_BYTE: begin
        case (ph)
          PH_WAIT_SOH: begin
            if (it.rx_byte == CH_SOH) begin
              ph = PH_CNT_HI;
            end else if (it.rx_byte == CH_NAK) begin
              r.status = ST_NAK_RX;
              ph = PH_IDLE;
            end
          end
          PH_CNT_HI: begin
            frame_len = {it.rx_byte, 8'h00};
            ph = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            frame_len = {frame_len[15:8], it.rx_byte};
            sum = '0;
            seen = '0;
            if (frame_len > limit) begin
              r.send_valid = 1'b1;
              r.send_byte  = CH_NAK;
              r.status     = ST_TOO_LARGE;
              ph = PH_IDLE;
            end else begin
              ph = (frame_len == 16'd0) ? PH_SUM_HI : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            r.data_valid = 1'b1;
            r.data_byte  = it.rx_byte;
            sum  = sum + {8'h00, it.rx_byte};
            seen = seen + 16'd1;
            if (seen >= frame_len) ph = PH_SUM_HI;
          end
          PH_SUM_HI: begin
            sum_hi = it.rx_byte;
            ph = PH_SUM_LO;
          end
          PH_SUM_LO: begin
            r.send_valid = 1'b1;
            if ({sum_hi, it.rx_byte} == sum) begin
              r.send_byte = CH_ACK;
              r.status    = ST_GOOD;
              ph = PH_IDLE;
            end else begin
              r.send_byte = CH_NAK;
              r.status    = ST_BAD_SUM;
              ph = PH_WAIT_SOH;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ph        = PH_IDLE;
      limit     = MAX_COUNT_RESET;
      frame_len = '0;
      seen      = '0;
      sum       = '0;
      sum_hi    = '0;
      replies_due.delete();
      replies_pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = replies_due.pop_front();
          check_field("send_valid", int'(want.send_valid), int'(out_item.send_valid));
          check_field("send_byte", int'(want.send_byte), int'(out_item.send_byte));
          check_field("data_valid", int'(want.data_valid), int'(out_item.data_valid));
          check_field("data_byte", int'(want.data_byte), int'(out_item.data_byte));
          check_field("status", int'(want.status), int'(out_item.status));
        end
        reply_idx++;
      end
      if (cfg_we) limit = cfg_wdata;
      if (in_valid && in_ready) replies_due.push_back(predict_reply(in_item));
      replies_pending <= replies_due.size();
    end
  end

endmodule

// ===== bench/enq_soh_frame_receiver_sum16_tb.sv =====
`timescale 1ns / 1ps
module enq_soh_frame_receiver_sum16_tb;
  import esr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;

  int          mismatches;
  int          replies_pending;
  int          cycles;
  int          sent;
  int          stall_left;
  bit          hold_req;
  bit          calm;
  logic [15:0] limit_now;

  enq_soh_frame_receiver_sum16 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  frame_reply_checker reply_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 5 && limit_now <= 600) return int'(limit_now);
    if (r < 70) n = $urandom_range(0, 8);
    else if (r < 95) n = $urandom_range(9, 40);
    else n = $urandom_range(41, 300);
    return (n > limit_now) ? int'(limit_now) : n;
  endfunction

  // any byte that neither opens a frame nor aborts the exchange
  function automatic logic [7:0] wait_filler();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_SOH || b == CH_NAK) b = 8'h7E;
    return b;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic push_item(input logic [1:0] f, input logic [7:0] b);
    int gap;
    in_item_t it;
    gap = pick_gap();
    it.func = f;
    it.rx_byte = b;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_replies_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_replies_done();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_now = v;
  endtask

  // SOH, count, payload, checksum; at position cut the item is replaced by cut_func
  task automatic send_body(input int count, input bit corrupt, input int cut,
                           input logic [1:0] cut_func);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  b;
    int          fill;
    sum = '0;
    chk = '0;
    fill = $urandom_range(0, 9);
    for (int i = 0; i < count + 5; i++) begin
      if (i == cut) begin
        push_item(cut_func, 8'($urandom_range(0, 255)));
        return;
      end
      if (i == 0) begin
        b = CH_SOH;
      end else if (i == 1) begin
        b = count[15:8];
      end else if (i == 2) begin
        b = count[7:0];
      end else if (i < count + 3) begin
        if (fill == 0) b = 8'hFF;
        else if (fill == 1) b = 8'h00;
        else b = 8'($urandom_range(0, 255));
        sum = sum + {8'h00, b};
      end else if (i == count + 3) begin
        chk = corrupt ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
        b = chk[15:8];
      end else begin
        b = chk[7:0];
      end
      push_item(FUNC_BYTE, b);
    end
  endtask

  task automatic run_episode();
    int r;
    int len;
    int cut;
    int over;
    r = $urandom_range(0, 99);
    len = pick_len();
    if (r < 60 || (r < 70 && limit_now == 16'hFFFF)) begin
      push_item(FUNC_START, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) push_item(FUNC_BYTE, wait_filler());
      if ($urandom_range(0, 4) == 0) begin
        send_body(len, 1'b1, -1, FUNC_TIMEOUT);
        len = pick_len();
      end
      send_body(len, 1'b0, -1, FUNC_TIMEOUT);
    end else if (r < 70) begin
      if ($urandom_range(0, 1) == 1) over = int'(limit_now) + 1;
      else over = $urandom_range(int'(limit_now) + 1, 65535);
      push_item(FUNC_START, 8'($urandom_range(0, 255)));
      push_item(FUNC_BYTE, CH_SOH);
      push_item(FUNC_BYTE, over[15:8]);
      push_item(FUNC_BYTE, over[7:0]);
    end else if (r < 78) begin
      if (limit_now == 16'hFFFF && $urandom_range(0, 3) == 0) begin
        len = 65535;
        cut = $urandom_range(0, 8);
      end else begin
        cut = $urandom_range(0, len + 4);
      end
      push_item(FUNC_START, 8'($urandom_range(0, 255)));
      send_body(len, 1'b0, cut, FUNC_TIMEOUT);
      if (cut >= 3 && $urandom_range(0, 1) == 1) send_body(pick_len(), 1'b0, -1, FUNC_TIMEOUT);
    end else if (r < 86) begin
      push_item(FUNC_START, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) push_item(FUNC_BYTE, wait_filler());
      push_item(FUNC_BYTE, CH_NAK);
    end else if (r < 93) begin
      repeat ($urandom_range(1, 6))
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      push_item(FUNC_START, 8'($urandom_range(0, 255)));
      send_body(len, 1'b0, $urandom_range(0, len + 4), FUNC_START);
      send_body(pick_len(), 1'b0, -1, FUNC_TIMEOUT);
    end
  endtask

  task automatic run_phase(input int n);
    int stop;
    stop = sent + n;
    while (sent < stop) run_episode();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    sent = 0;
    limit_now = MAX_COUNT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle inputs and the unused code
    push_item(FUNC_BYTE, 8'hFF);
    push_item(FUNC_TIMEOUT, 8'h00);
    push_item(2'd3, 8'hAA);
    // NAK while waiting for SOH
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_BYTE, 8'h7E);
    push_item(FUNC_BYTE, CH_NAK);
    // timeouts before the payload
    push_item(FUNC_START, 8'hFF);
    push_item(FUNC_TIMEOUT, 8'h55);
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_BYTE, CH_SOH);
    push_item(FUNC_TIMEOUT, 8'hFF);
    // count too large
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_BYTE, CH_SOH);
    push_item(FUNC_BYTE, 8'hFF);
    push_item(FUNC_BYTE, 8'hFF);
    // zero count, good checksum
    push_item(FUNC_START, 8'h00);
    send_body(0, 1'b0, -1, FUNC_TIMEOUT);
    // bad checksum, then payload timeout from the retry
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_BYTE, CH_SOH);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'h01);
    push_item(FUNC_BYTE, 8'hFF);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'hFE);
    send_body(2, 1'b0, 4, FUNC_TIMEOUT);

    hold_req = 1'b1;
    run_phase(150);
    write_limit(16'd0);
    run_phase(80);
    write_limit(16'hFFFF);
    run_phase(120);
    write_limit(16'd7);
    calm = 1'b1;
    run_phase(80);
    calm = 1'b0;
    write_limit(16'($urandom_range(1, 65534)));
    run_phase(100);
    write_limit(MAX_COUNT_RESET);
    run_phase(80);

    wait_replies_done();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/esr_pkg.sv
sv/esr_in_reg.sv
sv/esr_fsm.sv
sv/enq_soh_frame_receiver_sum16.sv
bench/frame_reply_checker.sv
bench/enq_soh_frame_receiver_sum16_tb.sv
